// ----- rtl/slmnc_pkg.sv -----
// ----------------------------------------------------------------------------
// slmnc_pkg
// Shared types and constants of the switch-level mux netlist checker.
// ----------------------------------------------------------------------------
package slmnc_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_TRANSISTORS_DEF = 32;
    localparam int NODE_COUNT_DEF      = 16;

    // Field and register widths.
    localparam int NODE_W     = 4;
    localparam int INDEX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int TCOUNT_W   = 6;
    localparam int TRUTH_W    = 8;
    localparam int VCOUNT_W   = 4;
    localparam int VEC_W      = 3;
    localparam int VEC_MAX    = 8;

    typedef logic [NODE_W-1:0] t_node;

    // Fixed node numbers of the cell.
    localparam t_node NODE_A    = 4'd0;
    localparam t_node NODE_B    = 4'd1;
    localparam t_node NODE_S    = 4'd2;
    localparam t_node NODE_OUT  = 4'd3;
    localparam t_node NODE_HIGH = 4'd4;
    localparam t_node NODE_LOW  = 4'd5;

    // Request opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TCOUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 2'd2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 4'd8;

    // One transistor of the netlist table.
    typedef struct packed {
        logic  ptype;
        t_node src;
        t_node gate;
        t_node drn;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic tbl_wr;
        logic vec_clear;
        logic vec_inc;
        logic vec_init;
        logic eval;
        logic rd_next;
        logic res_set;
        logic res_val;
        logic out_load;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic nvec_zero;
        logic ntr_zero;
        logic entry_last;
        logic vec_last;
        logic conflict;
        logic vec_ok;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/slmnc_dp.sv -----
// ----------------------------------------------------------------------------
// slmnc_dp
// Datapath: configuration registers, transistor table memory, node state,
// vector and entry counters, and the result register.
// ----------------------------------------------------------------------------
module slmnc_dp #(
    parameter int MAX_TRANSISTORS = slmnc_pkg::MAX_TRANSISTORS_DEF,
    parameter int NODE_COUNT      = slmnc_pkg::NODE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [slmnc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slmnc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [slmnc_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic                                i_conducts_high,
    input  slmnc_pkg::t_node                    i_source_node,
    input  slmnc_pkg::t_node                    i_gate_node,
    input  slmnc_pkg::t_node                    i_drain_node,
    input  slmnc_pkg::t_cmd                     i_cmd,
    output slmnc_pkg::t_status                  o_status,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_passed
);
    import slmnc_pkg::*;

    localparam int TW = (MAX_TRANSISTORS > 1) ? $clog2(MAX_TRANSISTORS) : 1;
    localparam int NW = $clog2(NODE_COUNT);

    logic [TCOUNT_W-1:0]   r_tcount;
    logic [TRUTH_W-1:0]    r_truth;
    logic [VCOUNT_W-1:0]   r_vcount;

    t_entry                r_table [MAX_TRANSISTORS];
    t_entry                r_rd_data;
    logic [TW-1:0]         rd_addr;
    logic [TW-1:0]         r_entry;
    logic [VEC_W-1:0]      r_vec;

    logic [NODE_COUNT-1:0] r_known;
    logic [NODE_COUNT-1:0] r_level;
    logic [NODE_COUNT-1:0] n_known;
    logic [NODE_COUNT-1:0] n_level;

    logic                  r_res;
    logic                  r_out_valid;
    logic                  r_passed;

    logic [TW:0]           ntr_sat;
    logic [VCOUNT_W-1:0]   nvec_sat;
    logic                  src_k, src_h, gate_k, gate_h, drn_k, drn_h;
    logic                  fire;
    logic                  conflict;
    logic                  out_k, out_h;

    // A node number outside the node set reads as unknown and low.
    function automatic logic node_bit(logic [NODE_COUNT-1:0] vec, t_node n);
        logic b;
        b = 1'b0;
        if (int'(n) < NODE_COUNT) begin
            b = vec[NW'(n)];
        end
        return b;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcount <= '0;
            r_truth  <= '0;
            r_vcount <= VCOUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TCOUNT: r_tcount <= i_cfg_data[TCOUNT_W-1:0];
                CFG_TRUTH:  r_truth  <= i_cfg_data[TRUTH_W-1:0];
                CFG_VCOUNT: r_vcount <= i_cfg_data[VCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated loop limits.
    assign ntr_sat  = (int'(r_tcount) > MAX_TRANSISTORS) ? (TW+1)'(MAX_TRANSISTORS)
                                                         : (TW+1)'(r_tcount);
    assign nvec_sat = (int'(r_vcount) > VEC_MAX) ? VCOUNT_W'(VEC_MAX) : r_vcount;

    // Transistor table: one write port for loads, one registered read port.
    assign rd_addr = i_cmd.vec_init ? '0 : r_entry + TW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && (int'(i_entry_index) < MAX_TRANSISTORS)) begin
            r_table[TW'(i_entry_index)] <= '{ptype: i_conducts_high,
                                             src:   i_source_node,
                                             gate:  i_gate_node,
                                             drn:   i_drain_node};
        end
        if (i_cmd.vec_init || i_cmd.rd_next) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    // Counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_vec   <= '0;
        end else begin
            if (i_cmd.vec_init) begin
                r_entry <= '0;
            end else if (i_cmd.rd_next) begin
                r_entry <= r_entry + TW'(1);
            end
            if (i_cmd.vec_clear) begin
                r_vec <= '0;
            end else if (i_cmd.vec_inc) begin
                r_vec <= r_vec + VEC_W'(1);
            end
        end
    end

    // Evaluation of the entry held in the read register.
    always_comb begin
        src_k  = node_bit(r_known, r_rd_data.src);
        src_h  = node_bit(r_level, r_rd_data.src);
        gate_k = node_bit(r_known, r_rd_data.gate);
        gate_h = node_bit(r_level, r_rd_data.gate);
        drn_k  = node_bit(r_known, r_rd_data.drn);
        drn_h  = node_bit(r_level, r_rd_data.drn);
        // A p-type conducts a high source on a low gate, an n-type a low
        // source on a high gate; the drain takes the source level.
        fire     = src_k && gate_k && (src_h == r_rd_data.ptype)
                   && (gate_h != r_rd_data.ptype);
        conflict = fire && drn_k && (drn_h != r_rd_data.ptype);
    end

    always_comb begin
        n_known = r_known;
        n_level = r_level;
        if (i_cmd.vec_init) begin
            n_known = '0;
            n_level = '0;
            n_known[NW'(NODE_A)]    = 1'b1;
            n_known[NW'(NODE_B)]    = 1'b1;
            n_known[NW'(NODE_S)]    = 1'b1;
            n_known[NW'(NODE_HIGH)] = 1'b1;
            n_known[NW'(NODE_LOW)]  = 1'b1;
            n_level[NW'(NODE_A)]    = r_vec[2];
            n_level[NW'(NODE_B)]    = r_vec[1];
            n_level[NW'(NODE_S)]    = r_vec[0];
            n_level[NW'(NODE_HIGH)] = 1'b1;
        end else if (i_cmd.eval && fire && !conflict
                     && (int'(r_rd_data.drn) < NODE_COUNT)) begin
            n_known[NW'(r_rd_data.drn)] = 1'b1;
            n_level[NW'(r_rd_data.drn)] = r_rd_data.ptype;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
            r_level <= '0;
        end else begin
            r_known <= n_known;
            r_level <= n_level;
        end
    end

    assign out_k = node_bit(r_known, NODE_OUT);
    assign out_h = node_bit(r_level, NODE_OUT);

    // Run result and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res <= i_cmd.res_val;
        end
        if (i_cmd.out_load) begin
            r_passed <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_passed    = r_passed;

    assign o_status.nvec_zero  = (nvec_sat == '0);
    assign o_status.ntr_zero   = (ntr_sat == '0);
    assign o_status.entry_last = (({1'b0, r_entry} + (TW+1)'(1)) == ntr_sat);
    assign o_status.vec_last   = ((VCOUNT_W'(r_vec) + VCOUNT_W'(1)) == nvec_sat);
    assign o_status.conflict   = conflict;
    assign o_status.vec_ok     = out_k && (out_h == r_truth[r_vec]);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

// ----- rtl/slmnc_ctrl.sv -----
// ----------------------------------------------------------------------------
// slmnc_ctrl
// Controller: sequences loads and runs, walking vectors and table entries.
// ----------------------------------------------------------------------------
module slmnc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_opcode,
    output logic                o_in_stall,
    input  slmnc_pkg::t_status  i_status,
    output slmnc_pkg::t_cmd     o_cmd
);
    import slmnc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.tbl_wr = 1'b1;
                    end else begin
                        o_cmd.vec_clear = 1'b1;
                        // With no vectors to check the run passes at once.
                        if (i_status.nvec_zero) begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_val = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_INIT: begin
                o_cmd.vec_init = 1'b1;
                n_state = i_status.ntr_zero ? S_CHECK : S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.conflict) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_val = 1'b0;
                    n_state       = S_DONE;
                end else if (i_status.entry_last) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_CHECK: begin
                if (!i_status.vec_ok) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_val = 1'b0;
                    n_state       = S_DONE;
                end else if (i_status.vec_last) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_val = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.vec_inc = 1'b1;
                    n_state       = S_INIT;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/switch_level_mux_netlist_checker_core.sv -----
// ----------------------------------------------------------------------------
// switch_level_mux_netlist_checker_core
// Switch-level checker of a transistor netlist for a mux cell.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid / o_in_stall) carries requests. A load request
// writes one entry of the transistor table and gives no result. A run request
// checks the loaded netlist against the expected truth table and gives one
// result on the output channel (o_out_valid / i_out_stall) carrying o_passed.
// Vector and transistor counts are used after saturation. For each vector the
// run sets up the nodes, walks the table entries one at a time through the
// single table read port, and then checks the out node. A conflict ends the
// run early. The worst case is 8 vectors of 32 entries.
// Requests are taken only while no run is in progress. A finished result waits
// in the output register while loads continue; a following run finishes but
// holds its result until the output register is free.
// Reset clears the control state, the node state and the configuration
// (vector count 8); the table stays unwritten until loaded.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
module switch_level_mux_netlist_checker_core #(
    parameter int MAX_TRANSISTORS = slmnc_pkg::MAX_TRANSISTORS_DEF,
    parameter int NODE_COUNT      = slmnc_pkg::NODE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [slmnc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slmnc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [slmnc_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic                                i_conducts_high,
    input  slmnc_pkg::t_node                    i_source_node,
    input  slmnc_pkg::t_node                    i_gate_node,
    input  slmnc_pkg::t_node                    i_drain_node,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_passed
);
    import slmnc_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_acc;

    slmnc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    slmnc_dp #(
        .MAX_TRANSISTORS (MAX_TRANSISTORS),
        .NODE_COUNT      (NODE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_entry_index   (i_entry_index),
        .i_conducts_high (i_conducts_high),
        .i_source_node   (i_source_node),
        .i_gate_node     (i_gate_node),
        .i_drain_node    (i_drain_node),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_passed        (o_passed)
    );

    assign in_acc = i_in_valid && !o_in_stall;

    // An accepted run keeps the input channel closed in the next cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_opcode == OP_RUN) |=> o_in_stall)
        else $error("run accepted but input not stalled");

    // An accepted load leaves the input channel open in the next cycle.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_opcode == OP_LOAD) |=> !o_in_stall)
        else $error("load did not complete in one cycle");

    // A new result only appears at the end of a run.
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared outside a run");

endmodule
